[hdl/sths_pkg.sv]
// Package for the spectrum table hero sampler.
// Shared constants, register index and opcode codes, reset values.
// No dependencies.
package sths_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned HERO_COUNT_DEF  = 4;

  localparam int unsigned IDX_W    = 10;
  localparam int unsigned VAL_W    = 16;
  localparam int unsigned WL_W     = 16;
  localparam int unsigned SCALE_W  = 24;
  localparam int unsigned USED_W   = 11;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned CFG_DW   = 24;
  localparam int unsigned CFG_IW   = 3;

  typedef enum logic [CFG_IW-1:0] {
    CFG_INTERP_MODE    = 3'd0,
    CFG_LOW_WAVELENGTH = 3'd1,
    CFG_INDEX_SCALE    = 3'd2,
    CFG_HERO_STEP      = 3'd3,
    CFG_ENTRIES_USED   = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic {
    MODE_NEAREST = 1'b0,
    MODE_LINEAR  = 1'b1
  } interp_mode_e;

  localparam logic              RST_INTERP_MODE  = 1'b1;
  localparam logic [WL_W-1:0]    RST_LOW_WL       = 16'd6080;
  localparam logic [SCALE_W-1:0] RST_INDEX_SCALE  = 24'd65536;
  localparam logic [WL_W-1:0]    RST_HERO_STEP    = 16'd1600;
  localparam logic [USED_W-1:0]  RST_ENTRIES_USED = 11'd1024;

endpackage

[hdl/sths_if.sv]
// Valid/ready channel interfaces for the hero sampler input and result streams.
// Depends on sths_pkg for field widths.
interface sths_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [sths_pkg::IDX_W-1:0]    entry_index;
  logic [sths_pkg::VAL_W-1:0]    entry_value;
  logic [sths_pkg::WL_W-1:0]     start_wavelength;

  modport source (output valid, op, entry_index, entry_value, start_wavelength,
                  input ready);
  modport sink (input valid, op, entry_index, entry_value, start_wavelength,
                output ready);
endinterface

interface sths_out_if;
  logic                          valid;
  logic                          ready;
  logic [sths_pkg::VAL_W-1:0]    sample_value;
  logic                          last;

  modport source (output valid, sample_value, last, input ready);
  modport sink (input valid, sample_value, last, output ready);
endinterface

[hdl/sths_ram.sv]
// Generic RAM: one write port, two registered read ports with read enable.
// No dependencies.
module sths_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata0_o,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata0_q;
  logic [WIDTH-1:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_q <= mem_q[raddr0_i];
      rdata1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

[hdl/spectrum_table_hero_sampler.sv]
// Spectrum table hero sampler: a sample item runs through the numbered stages and the
// output register, one result per cycle while results are taken; it holds the input
// for its whole hero run, and a write item only updates the table, with no result.
// The whole pipeline advances together and holds while the result is not taken.
// rst_ni (async, active low) clears valid bits and loads the configuration reset
// values; table contents stay undefined until written.
module spectrum_table_hero_sampler #(
  parameter int unsigned TABLE_DEPTH = sths_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned HERO_COUNT  = sths_pkg::HERO_COUNT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sths_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [sths_pkg::CFG_DW-1:0] cfg_wdata_i,
  sths_in_if.sink                     in_if,
  sths_out_if.source                  out_if
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned KW = (HERO_COUNT > 1) ? $clog2(HERO_COUNT) : 1;
  localparam int unsigned WW = sths_pkg::WL_W + $clog2(HERO_COUNT);
  localparam int unsigned PW = WW + sths_pkg::SCALE_W;
  localparam int unsigned MW = PW - 20 + 1;
  localparam int unsigned LW = ($clog2(TABLE_DEPTH + 1) > sths_pkg::USED_W) ?
                               $clog2(TABLE_DEPTH + 1) : sths_pkg::USED_W;
  localparam int unsigned CW = ((MW + 1) > LW) ? (MW + 1) : LW;
  localparam int unsigned FW = sths_pkg::FRAC_W;
  localparam int unsigned VW = sths_pkg::VAL_W;
  localparam int unsigned IW = sths_pkg::IDX_W;

  // configuration
  logic                          mode_q;
  logic [sths_pkg::WL_W-1:0]     low_q;
  logic [sths_pkg::SCALE_W-1:0]  scale_q;
  logic [sths_pkg::WL_W-1:0]     step_q;
  logic [sths_pkg::USED_W-1:0]   used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= sths_pkg::RST_INTERP_MODE;
      low_q   <= sths_pkg::RST_LOW_WL;
      scale_q <= sths_pkg::RST_INDEX_SCALE;
      step_q  <= sths_pkg::RST_HERO_STEP;
      used_q  <= sths_pkg::RST_ENTRIES_USED;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sths_pkg::CFG_INTERP_MODE:    mode_q  <= cfg_wdata_i[0];
        sths_pkg::CFG_LOW_WAVELENGTH: low_q   <= cfg_wdata_i[sths_pkg::WL_W-1:0];
        sths_pkg::CFG_INDEX_SCALE:    scale_q <= cfg_wdata_i[sths_pkg::SCALE_W-1:0];
        sths_pkg::CFG_HERO_STEP:      step_q  <= cfg_wdata_i[sths_pkg::WL_W-1:0];
        sths_pkg::CFG_ENTRIES_USED:   used_q  <= cfg_wdata_i[sths_pkg::USED_W-1:0];
        default: ;
      endcase
    end
  end

  logic [LW-1:0] lim;
  assign lim = (LW'(used_q) < LW'(TABLE_DEPTH)) ? LW'(used_q) : LW'(TABLE_DEPTH);

  // pipeline registers
  logic adv;
  logic out_vld_q;

  // stage 0: issue, steps through hero wavelengths
  logic          r0_vld_q, r0_vld_d;
  logic          r0_smp_q, r0_smp_d;
  logic [KW-1:0] r0_k_q, r0_k_d;
  logic [WW-1:0] r0_w_q, r0_w_d;
  logic [IW-1:0] r0_widx_q, r0_widx_d;
  logic [VW-1:0] r0_wval_q, r0_wval_d;
  logic          run_more;
  logic          r0_last;

  assign adv      = !out_vld_q || out_if.ready;
  assign run_more = r0_vld_q && r0_smp_q && (r0_k_q != KW'(HERO_COUNT - 1));
  assign r0_last  = r0_smp_q && (r0_k_q == KW'(HERO_COUNT - 1));
  assign in_if.ready = adv && !run_more;

  always_comb begin
    r0_vld_d  = r0_vld_q;
    r0_smp_d  = r0_smp_q;
    r0_k_d    = r0_k_q;
    r0_w_d    = r0_w_q;
    r0_widx_d = r0_widx_q;
    r0_wval_d = r0_wval_q;
    if (adv) begin
      if (run_more) begin
        r0_k_d = r0_k_q + KW'(1);
        r0_w_d = r0_w_q + WW'(step_q);
      end else begin
        r0_vld_d  = in_if.valid;
        r0_smp_d  = (in_if.op == sths_pkg::OP_SAMPLE);
        r0_k_d    = '0;
        r0_w_d    = WW'(in_if.start_wavelength);
        r0_widx_d = in_if.entry_index;
        r0_wval_d = in_if.entry_value;
      end
    end
  end

  // stage 1: signed offset from low wavelength
  logic          r1_vld_q, r1_smp_q, r1_last_q, r1_neg_q;
  logic [WW-1:0] r1_mag_q;
  logic [IW-1:0] r1_widx_q;
  logic [VW-1:0] r1_wval_q;
  logic          s1_neg;
  logic [WW-1:0] s1_mag;

  assign s1_neg = r0_w_q < WW'(low_q);
  assign s1_mag = s1_neg ? (WW'(low_q) - r0_w_q) : (r0_w_q - WW'(low_q));

  // stage 2: product, index in Q.20
  logic          r2_vld_q, r2_smp_q, r2_last_q, r2_neg_q;
  logic [PW-1:0] r2_prod_q;
  logic [IW-1:0] r2_widx_q;
  logic [VW-1:0] r2_wval_q;

  // stage 3: index magnitude and fraction
  logic          r3_vld_q, r3_smp_q, r3_last_q, r3_neg_q;
  logic [MW-1:0] r3_ma_q;
  logic [FW-1:0] r3_f_q;
  logic [IW-1:0] r3_widx_q;
  logic [VW-1:0] r3_wval_q;
  logic          s3_inc;
  logic [FW-1:0] s3_f;
  logic [20:0]   s3_qlow;

  assign s3_qlow = 21'(r2_prod_q[19:0]) + 21'd15;

  always_comb begin
    s3_inc = 1'b0;
    s3_f   = '0;
    if (mode_q == sths_pkg::MODE_NEAREST) begin
      s3_inc = r2_prod_q[19];
    end else if (!r2_neg_q) begin
      s3_f = r2_prod_q[19:4];
    end else begin
      s3_inc = |r2_prod_q[19:0];
      s3_f   = FW'(0) - s3_qlow[19:4];
    end
  end

  // stage 4: range check, table read (write items update the table here)
  logic          r4_vld_q, r4_last_q, r4_ok0_q, r4_ok1_q;
  logic [FW-1:0] r4_f_q;
  logic          s4_npos, s4_ok0, s4_ok1, s4_we;
  logic [CW-1:0] s4_a0, s4_a1;
  logic [AW-1:0] s4_raddr1;
  logic [VW-1:0] rd0, rd1;

  assign s4_npos   = !r3_neg_q || (r3_ma_q == '0);
  assign s4_a0     = CW'(r3_ma_q);
  assign s4_a1     = CW'(r3_ma_q) + CW'(1);
  assign s4_ok0    = s4_npos && (s4_a0 < CW'(lim));
  assign s4_ok1    = (r3_f_q != '0) &&
                     (s4_npos ? (s4_a1 < CW'(lim)) : ((r3_ma_q == MW'(1)) && (lim != '0)));
  assign s4_raddr1 = s4_npos ? s4_a1[AW-1:0] : '0;
  assign s4_we     = adv && r3_vld_q && !r3_smp_q && (32'(r3_widx_q) < TABLE_DEPTH);

  sths_ram #(
    .WIDTH (VW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i    (clk_i),
    .we_i     (s4_we),
    .waddr_i  (AW'(r3_widx_q)),
    .wdata_i  (r3_wval_q),
    .re_i     (adv),
    .raddr0_i (s4_a0[AW-1:0]),
    .raddr1_i (s4_raddr1),
    .rdata0_o (rd0),
    .rdata1_o (rd1)
  );

  // stage 5: weighted neighbors
  logic          r5_vld_q, r5_last_q;
  logic [32:0]   r5_p0_q;
  logic [31:0]   r5_p1_q;
  logic [VW-1:0] s5_v0, s5_v1;

  assign s5_v0 = r4_ok0_q ? rd0 : '0;
  assign s5_v1 = r4_ok1_q ? rd1 : '0;

  // output register
  logic          out_last_q;
  logic [VW-1:0] out_val_q;
  logic [33:0]   s6_sum;

  assign s6_sum = 34'(r5_p0_q) + 34'(r5_p1_q) + 34'd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r0_vld_q  <= 1'b0;
      r0_k_q    <= '0;
      r1_vld_q  <= 1'b0;
      r2_vld_q  <= 1'b0;
      r3_vld_q  <= 1'b0;
      r4_vld_q  <= 1'b0;
      r5_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      r0_vld_q <= r0_vld_d;
      r0_k_q   <= r0_k_d;
      if (adv) begin
        r1_vld_q  <= r0_vld_q;
        r2_vld_q  <= r1_vld_q;
        r3_vld_q  <= r2_vld_q;
        r4_vld_q  <= r3_vld_q && r3_smp_q;
        r5_vld_q  <= r4_vld_q;
        out_vld_q <= r5_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r0_smp_q  <= r0_smp_d;
    r0_w_q    <= r0_w_d;
    r0_widx_q <= r0_widx_d;
    r0_wval_q <= r0_wval_d;
    if (adv) begin
      r1_smp_q   <= r0_smp_q;
      r1_last_q  <= r0_last;
      r1_neg_q   <= s1_neg;
      r1_mag_q   <= s1_mag;
      r1_widx_q  <= r0_widx_q;
      r1_wval_q  <= r0_wval_q;

      r2_smp_q   <= r1_smp_q;
      r2_last_q  <= r1_last_q;
      r2_neg_q   <= r1_neg_q;
      r2_prod_q  <= PW'(r1_mag_q) * PW'(scale_q);
      r2_widx_q  <= r1_widx_q;
      r2_wval_q  <= r1_wval_q;

      r3_smp_q   <= r2_smp_q;
      r3_last_q  <= r2_last_q;
      r3_neg_q   <= r2_neg_q;
      r3_ma_q    <= MW'(r2_prod_q[PW-1:20]) + MW'(s3_inc);
      r3_f_q     <= s3_f;
      r3_widx_q  <= r2_widx_q;
      r3_wval_q  <= r2_wval_q;

      r4_last_q  <= r3_last_q;
      r4_ok0_q   <= s4_ok0;
      r4_ok1_q   <= s4_ok1;
      r4_f_q     <= r3_f_q;

      r5_last_q  <= r4_last_q;
      r5_p0_q    <= 33'(s5_v0) * (33'h1_0000 - 33'(r4_f_q));
      r5_p1_q    <= 32'(s5_v1) * 32'(r4_f_q);

      out_last_q <= r5_last_q;
      out_val_q  <= s6_sum[31:16];
    end
  end

  assign out_if.valid        = out_vld_q;
  assign out_if.sample_value = out_val_q;
  assign out_if.last         = out_last_q;

endmodule

[hdl/sths_checker.sv]
// Port-level checker for the hero sampler, bound to the top level.
// Depends on sths_pkg and spectrum_table_hero_sampler.
module sths_checker #(
  parameter int unsigned HERO_COUNT = sths_pkg::HERO_COUNT_DEF
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_op,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [sths_pkg::VAL_W-1:0] out_value,
  input logic                       out_last
);

  // stalled result transaction holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last))
    else $error("stalled result changed");

  // a stalled result stops intake
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken during output stall");

  // a sample transaction keeps the input busy for its hero run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (HERO_COUNT > 1) && in_valid && in_ready && (in_op == sths_pkg::OP_SAMPLE)
    |=> !in_ready)
    else $error("input ready during hero run");

  // no results out of reset
  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid)
    else $error("result valid in reset");

endmodule

bind spectrum_table_hero_sampler sths_checker #(
  .HERO_COUNT (HERO_COUNT)
) u_sths_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .in_op     (in_if.op),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_value (out_if.sample_value),
  .out_last  (out_if.last)
);
